// ----- rtl/clipped_window_median_filter_unit_defines.svh -----
// Assertion macros for the clipped window median filter.
`ifndef CLIPPED_WINDOW_MEDIAN_FILTER_UNIT_DEFINES_SVH
`define CLIPPED_WINDOW_MEDIAN_FILTER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CWM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CWM_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CWM_ASSERT(label, clk, rst_n, prop, msg)
`define CWM_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ----- rtl/cwmf_pkg.sv -----
// Package with item types, register indexes and controller states.
`default_nettype none
package cwmf_pkg;
  typedef struct packed {
    logic        action;
    logic [5:0]  column;
    logic [5:0]  row;
    logic [15:0] pixel_value;
  } cwmf_in_t;

  typedef struct packed {
    logic [16:0] median_half_units;
    logic [7:0]  window_count;
  } cwmf_out_t;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_HX     = 2'd2;
  localparam logic [1:0] REG_HY     = 2'd3;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_GATHER,
    ST_SELECT,
    ST_PICK,
    ST_DONE
  } cwmf_state_t;

  typedef struct packed {
    logic store_write;
    logic query_start;
    logic setup;
    logic gather;
    logic sel_start;
    logic sel_step;
    logic pick;
  } cwmf_cmd_t;

  typedef struct packed {
    logic gather_done;
    logic sel_done;
  } cwmf_status_t;
endpackage
`default_nettype wire

// ----- rtl/cwmf_ctrl.sv -----
// Controller state machine for the median filter.
`default_nettype none
`include "clipped_window_median_filter_unit_defines.svh"
module cwmf_ctrl
  import cwmf_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire logic         in_action,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  output cwmf_cmd_t         cmd,
  input  wire cwmf_status_t stat
);
  cwmf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_action == ACT_WRITE) begin
            cmd.store_write = 1'b1;
          end else begin
            cmd.query_start = 1'b1;
            state_nxt = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_GATHER;
      end
      ST_GATHER: begin
        cmd.gather = 1'b1;
        if (stat.gather_done) begin
          state_nxt = ST_SELECT;
        end
      end
      ST_SELECT: begin
        cmd.sel_start = 1'b1;
        state_nxt = ST_PICK;
      end
      ST_PICK: begin
        cmd.sel_step = 1'b1;
        if (stat.sel_done) begin
          cmd.pick = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `CWM_ASSERT(a_ready_idle, clk, rst_n, in_ready |-> state_r == ST_IDLE, "ready outside idle")
  `CWM_ASSERT(a_query_goes, clk, rst_n, (in_valid && in_ready && in_action == ACT_QUERY) |=> state_r == ST_SETUP, "query not started")
  `CWM_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> out_valid, "result dropped")
endmodule
`default_nettype wire

// ----- rtl/cwmf_datapath.sv -----
// Datapath: pixel store, window gather and rank selection.
`default_nettype none
module cwmf_datapath
  import cwmf_pkg::*;
#(
  parameter int MAX_WIDTH = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_HALF_WINDOW = 7,
  parameter int PIXEL_BITS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cwmf_in_t   in_item,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_addr,
  input  wire logic [6:0] cfg_wdata,
  input  wire cwmf_cmd_t  cmd,
  output cwmf_status_t    stat,
  output cwmf_out_t       result
);
  localparam int XW = $clog2(MAX_WIDTH) > 0 ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = $clog2(MAX_HEIGHT) > 0 ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW = XW + YW;
  localparam int DEPTH = 1 << AW;
  localparam int WSIDE = 2 * MAX_HALF_WINDOW + 1;
  localparam int WDEPTH = WSIDE * WSIDE;
  localparam int WA = $clog2(WDEPTH) > 0 ? $clog2(WDEPTH) : 1;
  localparam int NW = $clog2(WDEPTH + 1);
  localparam int CW = 12;

  logic [6:0] width_r, height_r;
  logic [2:0] hx_r, hy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 7'd64;
      height_r <= 7'd64;
      hx_r <= 3'd1;
      hy_r <= 3'd1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_WIDTH:  width_r <= cfg_wdata;
        REG_HEIGHT: height_r <= cfg_wdata;
        REG_HX:     hx_r <= cfg_wdata[2:0];
        REG_HY:     hy_r <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  logic [PIXEL_BITS-1:0] store_mem [DEPTH];
  logic [PIXEL_BITS-1:0] store_q;
  logic [PIXEL_BITS-1:0] win_mem [WDEPTH];
  logic [PIXEL_BITS-1:0] win_q;

  logic [CW-1:0] col_r, row_r, x0_r, x1_r, y1_r, x_r, y_r;
  logic [NW-1:0] n_r, wr_idx_r;
  logic          rd_pend_r, rd_last_r, scan_done_r;
  logic [NW-1:0] cand_r, scan_r, target_r;
  logic [NW-1:0] less_r, leq_r;
  logic [PIXEL_BITS-1:0] cand_v_r, lo_v_r;
  logic          second_r, rd_cand_r;
  logic          done_r;

  logic [CW-1:0] w_c, h_c, hx_c, hy_c, c_c, r_c;
  logic [CW-1:0] ext_col, ext_row;

  always_comb begin
    w_c = CW'(width_r);
    if (w_c == '0) w_c = CW'(1);
    if (w_c > CW'(MAX_WIDTH)) w_c = CW'(MAX_WIDTH);
    h_c = CW'(height_r);
    if (h_c == '0) h_c = CW'(1);
    if (h_c > CW'(MAX_HEIGHT)) h_c = CW'(MAX_HEIGHT);
    hx_c = CW'(hx_r);
    if (hx_c > CW'(MAX_HALF_WINDOW)) hx_c = CW'(MAX_HALF_WINDOW);
    hy_c = CW'(hy_r);
    if (hy_c > CW'(MAX_HALF_WINDOW)) hy_c = CW'(MAX_HALF_WINDOW);
    c_c = (col_r >= w_c) ? w_c - CW'(1) : col_r;
    r_c = (row_r >= h_c) ? h_c - CW'(1) : row_r;
    ext_col = CW'(in_item.column);
    ext_row = CW'(in_item.row);
  end

  logic wr_ok;
  logic [AW-1:0] wr_addr, rd_addr;
  assign wr_ok = cmd.store_write && ext_col < CW'(MAX_WIDTH) && ext_row < CW'(MAX_HEIGHT);
  assign wr_addr = {ext_row[YW-1:0], ext_col[XW-1:0]};
  assign rd_addr = {y_r[YW-1:0], x_r[XW-1:0]};

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      store_mem[wr_addr] <= PIXEL_BITS'(in_item.pixel_value);
    end
    store_q <= store_mem[rd_addr];
  end

  // Gather: walk the clipped window in raster order, one pixel read a cycle.
  logic gather_rd;
  assign gather_rd = cmd.gather && !scan_done_r;

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      col_r <= ext_col;
      row_r <= ext_row;
    end
    if (cmd.setup) begin
      x0_r <= (c_c > hx_c) ? c_c - hx_c : '0;
      x1_r <= (c_c + hx_c + CW'(1) > w_c) ? w_c : c_c + hx_c + CW'(1);
      y1_r <= (r_c + hy_c + CW'(1) > h_c) ? h_c : r_c + hy_c + CW'(1);
      x_r <= (c_c > hx_c) ? c_c - hx_c : '0;
      y_r <= (r_c > hy_c) ? r_c - hy_c : '0;
    end else if (gather_rd) begin
      if (x_r + CW'(1) >= x1_r) begin
        x_r <= x0_r;
        y_r <= y_r + CW'(1);
      end else begin
        x_r <= x_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
      rd_last_r <= 1'b0;
      scan_done_r <= 1'b0;
      wr_idx_r <= '0;
    end else if (cmd.setup) begin
      rd_pend_r <= 1'b0;
      rd_last_r <= 1'b0;
      scan_done_r <= 1'b0;
      wr_idx_r <= '0;
    end else if (cmd.gather) begin
      rd_pend_r <= gather_rd;
      rd_last_r <= gather_rd && (x_r + CW'(1) >= x1_r) && (y_r + CW'(1) >= y1_r);
      if (gather_rd && (x_r + CW'(1) >= x1_r) && (y_r + CW'(1) >= y1_r)) begin
        scan_done_r <= 1'b1;
      end
      if (rd_pend_r) begin
        wr_idx_r <= wr_idx_r + NW'(1);
      end
    end
  end

  assign stat.gather_done = rd_pend_r && rd_last_r;

  // Selection: for each candidate count elements less and less-or-equal;
  // the candidate is the k-th smallest when less <= k < leq.
  logic [WA-1:0] win_rd_addr;
  logic          cand_ok;
  logic          found;
  assign win_rd_addr = rd_cand_r ? cand_r[WA-1:0] : scan_r[WA-1:0];
  assign cand_ok = (less_r <= target_r) && (target_r < leq_r);

  always_ff @(posedge clk) begin
    if (cmd.gather && rd_pend_r) begin
      win_mem[wr_idx_r[WA-1:0]] <= store_q;
    end
    win_q <= win_mem[win_rd_addr];
  end

  logic [NW-1:0] n_w;
  assign n_w = wr_idx_r;

  // Sub-phases: rd_cand_r issues the candidate read, then the scan compares.
  logic          cand_lat_r;
  logic          scan_val_r;
  logic          scan_last_r;
  logic [PIXEL_BITS-1:0] cv;
  assign cv = cand_v_r;
  assign found = scan_done_r && !scan_val_r && !rd_cand_r && !cand_lat_r && cand_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
      rd_cand_r <= 1'b0;
      cand_lat_r <= 1'b0;
      scan_val_r <= 1'b0;
      scan_last_r <= 1'b0;
      second_r <= 1'b0;
    end else if (cmd.sel_start) begin
      n_r <= n_w;
      target_r <= n_w[0] ? (n_w >> 1) : (n_w >> 1) - NW'(1);
      cand_r <= '0;
      rd_cand_r <= 1'b1;
      cand_lat_r <= 1'b0;
      scan_val_r <= 1'b0;
      second_r <= 1'b0;
      done_r <= 1'b0;
    end else if (cmd.sel_step && !done_r) begin
      if (rd_cand_r) begin
        rd_cand_r <= 1'b0;
        cand_lat_r <= 1'b1;
        scan_r <= '0;
        less_r <= '0;
        leq_r <= '0;
      end else if (cand_lat_r) begin
        cand_lat_r <= 1'b0;
        cand_v_r <= win_q;
        scan_r <= scan_r + NW'(1);
        scan_val_r <= 1'b1;
        scan_last_r <= (n_r == NW'(1));
      end else if (scan_val_r) begin
        if (win_q < cv) less_r <= less_r + NW'(1);
        if (win_q <= cv) leq_r <= leq_r + NW'(1);
        if (scan_last_r) begin
          scan_val_r <= 1'b0;
        end else begin
          scan_r <= scan_r + NW'(1);
          scan_last_r <= (scan_r + NW'(1) == n_r);
        end
      end else begin
        if (cand_ok) begin
          if (n_r[0] || second_r) begin
            done_r <= 1'b1;
          end else begin
            lo_v_r <= cv;
            second_r <= 1'b1;
            target_r <= target_r + NW'(1);
            if (target_r + NW'(1) < leq_r) begin
              done_r <= 1'b1;
            end else begin
              cand_r <= '0;
              rd_cand_r <= 1'b1;
            end
          end
        end else begin
          cand_r <= cand_r + NW'(1);
          rd_cand_r <= 1'b1;
        end
      end
    end
  end

  // done_r covers both the repeated-value and second-pass cases.
  logic [PIXEL_BITS:0] sum_w;
  always_comb begin
    if (n_r[0]) begin
      sum_w = {cv, 1'b0};
    end else if (second_r && !(target_r < leq_r && lo_v_r == cv && found)) begin
      sum_w = (PIXEL_BITS + 1)'(lo_v_r) + (PIXEL_BITS + 1)'(cv);
    end else begin
      sum_w = {cv, 1'b0};
    end
  end

  assign stat.sel_done = done_r;

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      result.median_half_units <= 17'(sum_w);
      result.window_count <= 8'(n_r);
    end
  end
endmodule
`default_nettype wire

// ----- rtl/clipped_window_median_filter_unit.sv -----
// A query gathers the N pixels of the clipped window, where N is the window count,
// then tries rank candidates over at most two passes, so at most 2N in all.
// Throughput: one item at a time; the window buffer port bounds the rank scan.
// Reset: synchronous active low; registers return to 64x64 and reach 1.
// The pixel store has no reset; unwritten pixels read as undefined.
`default_nettype none
module clipped_window_median_filter_unit
  import cwmf_pkg::*;
#(
  parameter int MAX_WIDTH = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_HALF_WINDOW = 7,
  parameter int PIXEL_BITS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire cwmf_in_t   in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output cwmf_out_t       out_data,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_addr,
  input  wire logic [6:0] cfg_wdata
);
  cwmf_cmd_t    cmd;
  cwmf_status_t stat;

  cwmf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_action(in_data.action),
    .in_ready(in_ready), .out_valid(out_valid), .out_ready(out_ready),
    .cmd(cmd), .stat(stat)
  );

  cwmf_datapath #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_HALF_WINDOW(MAX_HALF_WINDOW), .PIXEL_BITS(PIXEL_BITS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_data), .cfg_we(cfg_we),
    .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata), .cmd(cmd), .stat(stat),
    .result(out_data)
  );
endmodule
`default_nettype wire
